@@ sv/igac_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igac_pkg: shared types and constants for the IMU conditioner
// Register indexes, request and result payloads, arithmetic unit opcodes
// and the saturation helper.
// ----------------------------------------------------------------------------
package igac_pkg;

  localparam int unsigned NumRegs = 8;
  localparam int unsigned RegIdxW = 3;
  localparam int unsigned CfgDataW = 64;
  localparam logic [7:0] StillRunMax = 8'd255;

  typedef enum logic [RegIdxW-1:0] {
    REG_GYRO_SCALE  = 3'd0,
    REG_ACCEL_SCALE = 3'd1,
    REG_STILL_THR   = 3'd2,
    REG_FILT_ALPHA  = 3'd3,
    REG_DEADBAND    = 3'd4,
    REG_STAT_SAMP   = 3'd5,
    REG_RECAL_MS    = 3'd6,
    REG_BIAS_ALPHA  = 3'd7
  } reg_idx_e;

  // input request payload
  typedef struct packed {
    logic signed [15:0] raw_accel_x;
    logic signed [15:0] raw_accel_y;
    logic signed [15:0] raw_accel_z;
    logic signed [15:0] raw_gyro_x;
    logic signed [15:0] raw_gyro_y;
    logic signed [15:0] raw_gyro_z;
    logic [15:0]        fusion_still_count;
    logic signed [31:0] gravity_x;
    logic signed [31:0] gravity_y;
    logic signed [31:0] gravity_z;
    logic [31:0]        time_ms;
  } sample_t;

  // result payload
  typedef struct packed {
    logic signed [31:0] rate_x;
    logic signed [31:0] rate_y;
    logic signed [31:0] rate_z;
    logic signed [31:0] smooth_x;
    logic signed [31:0] smooth_y;
    logic signed [31:0] smooth_z;
    logic signed [31:0] corrected_accel_x;
    logic signed [31:0] corrected_accel_y;
    logic signed [31:0] corrected_accel_z;
    logic [7:0]         gyro_still_run;
    logic [31:0]        smooth_magnitude;
  } result_t;

  // shared unit opcodes
  typedef enum logic [1:0] {
    OP_SCALE = 2'd0,  // a * b, round shift by scale shift
    OP_EMA   = 2'd1,  // a * b, round shift by 16
    OP_SQ    = 2'd2   // a * b, no shift
  } alu_op_e;

  typedef struct packed {
    logic        start;
    alu_op_e     op;
  } alu_ctrl_t;

  // saturate a 66-bit signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -66'sh0_8000_0000) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

@@ sv/igac_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igac_if: valid/ready channel
// Carries one payload of generic type.
// ----------------------------------------------------------------------------
interface igac_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/igac_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igac_mul: shared multiply and round unit
// One registered 34x34 signed product, then a combinational rounding shift.
// ----------------------------------------------------------------------------
module igac_mul #(
  parameter int unsigned ScaleShift = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  igac_pkg::alu_ctrl_t    ctrl_i,
  input  logic signed [33:0]     a_i,
  input  logic signed [33:0]     b_i,
  output logic signed [65:0]     res_o,
  output logic                   done_o
);

  logic signed [67:0] prod_q, prod_d;
  igac_pkg::alu_op_e  op_q;
  logic               v_q;
  logic signed [67:0] rnd;

  assign prod_d = 68'(a_i) * 68'(b_i);

  // product register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= 1'b0;
      op_q <= igac_pkg::OP_SQ;
    end else begin
      v_q  <= ctrl_i.start;
      op_q <= ctrl_i.op;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) prod_q <= prod_d;
  end

  // rounding shift, ties toward +inf
  always_comb begin
    rnd = prod_q;
    unique case (op_q)
      igac_pkg::OP_SCALE: begin
        if (ScaleShift == 0) rnd = prod_q;
        else rnd = (prod_q + (68'sd1 <<< (ScaleShift - 1))) >>> ScaleShift;
      end
      igac_pkg::OP_EMA: rnd = (prod_q + 68'sd32768) >>> 16;
      default: rnd = prod_q;
    endcase
  end

  assign res_o  = rnd[65:0];
  assign done_o = v_q;

endmodule

@@ sv/igac_sqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igac_sqrt: iterative floor square root
// One root bit per cycle over a 66-bit radicand, 33 steps then a done pulse.
// ----------------------------------------------------------------------------
module igac_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [65:0] rad_i,
  output logic [32:0] root_o,
  output logic        done_o
);

  logic [65:0] rem_q, rem_d;
  logic [65:0] val_q, val_d;
  logic [32:0] root_q, root_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [65:0] trial;
  logic [65:0] rem_sh;

  // one restoring step per cycle
  always_comb begin
    rem_sh = {rem_q[63:0], val_q[65:64]};
    trial  = {31'd0, root_q, 2'b01};
    rem_d  = rem_q;
    val_d  = val_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      val_d  = rad_i;
      root_d = '0;
      cnt_d  = 6'd33;
      busy_d = 1'b1;
    end else if (busy_q) begin
      val_d = {val_q[63:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[31:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[31:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    val_q  <= val_d;
    root_q <= root_d;
  end

  assign root_o = root_q;
  assign done_o = done_q;

endmodule

@@ sv/imu_gyro_accel_conditioner.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_gyro_accel_conditioner: IMU scaling, bias tracking, EMA and deadband
// Each request takes 16 products (22 when the biases track) through one
//   shared multiplier, then the bias step and a square root.
// One request at a time: the result stays in an output register until taken
//   and in is not ready then.
// Reset clears biases, filter, still run and restores register defaults.
// ----------------------------------------------------------------------------
module imu_gyro_accel_conditioner #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  igac_if.sink                         in_if,
  igac_if.source                       out_if,
  input  logic                         cfg_we_i,
  input  logic [igac_pkg::RegIdxW-1:0] cfg_idx_i,
  input  logic [igac_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned ScaleShift = 24 - FRAC_BITS;

  // configuration
  logic [23:0] gscale_q, ascale_q;
  logic [30:0] thr_q, db_q;
  logic [15:0] falpha_q, nstat_q;
  logic [31:0] recal_q;
  logic [63:0] balpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gscale_q <= 24'd256140;
      ascale_q <= 24'd1024;
      thr_q    <= 31'd65536;
      falpha_q <= 16'd16384;
      db_q     <= 31'd32768;
      nstat_q  <= 16'd100;
      recal_q  <= 32'd1000;
      balpha_q <= '0;
    end else if (cfg_we_i) begin
      unique case (igac_pkg::reg_idx_e'(cfg_idx_i))
        igac_pkg::REG_GYRO_SCALE:  gscale_q <= cfg_data_i[23:0];
        igac_pkg::REG_ACCEL_SCALE: ascale_q <= cfg_data_i[23:0];
        igac_pkg::REG_STILL_THR:   thr_q    <= cfg_data_i[30:0];
        igac_pkg::REG_FILT_ALPHA:  falpha_q <= cfg_data_i[15:0];
        igac_pkg::REG_DEADBAND:    db_q     <= cfg_data_i[30:0];
        igac_pkg::REG_STAT_SAMP:   nstat_q  <= cfg_data_i[15:0];
        igac_pkg::REG_RECAL_MS:    recal_q  <= cfg_data_i[31:0];
        igac_pkg::REG_BIAS_ALPHA:  balpha_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  typedef enum logic [3:0] {
    S_IDLE, S_SCALE, S_SQ, S_THR, S_FILT, S_BIAS, S_MAG, S_ROOT, S_OUT
  } state_e;

  // step list: scale 6, rate squares 3, threshold 1, filter 3, bias 6,
  // filtered squares 3
  state_e             state_q;
  logic [2:0]         k_q;        // step within phase
  logic               wait_q;     // product in flight
  logic [15:0]        raw_q [6];
  logic signed [31:0] grav_q [3];
  logic [15:0]        cnt_q;
  logic [31:0]        now_q;
  logic signed [31:0] gsc_q [3], asc_q [3], rate_q [3], acc_q [3];
  logic signed [31:0] gbias_q [3], abias_q [3], filt_q [3];
  logic               fseed_q, aseed_q, upd1_q, doupd_q, recal_sel_q;
  logic [31:0]        last_q;
  logic [7:0]         run_q;
  logic [65:0]        sum_q;
  logic               sq_start;
  logic [65:0]        sq_rad;
  logic [32:0]        root;
  logic               sq_done;

  igac_pkg::alu_ctrl_t alu_ctrl;
  logic signed [33:0]  mul_a, mul_b;
  logic signed [65:0]  mul_res;
  logic                mul_done;

  igac_mul #(.ScaleShift(ScaleShift)) u_mul (
    .clk_i, .rst_ni, .ctrl_i(alu_ctrl), .a_i(mul_a), .b_i(mul_b),
    .res_o(mul_res), .done_o(mul_done)
  );

  // radicand includes the last square, which lands on the start edge
  assign sq_rad = sum_q + 66'(mul_res);

  igac_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .rad_i(sq_rad),
    .root_o(root), .done_o(sq_done)
  );

  logic [1:0] ax;
  assign ax = (k_q >= 3'd3) ? 2'(k_q - 3'd3) : k_q[1:0];

  // bias targets
  logic signed [32:0] ameas_grav;
  logic [15:0]        ga, aa;
  assign ameas_grav = 33'(asc_q[ax]) - 33'(grav_q[ax]);
  assign ga = recal_sel_q ? balpha_q[31:16] : balpha_q[15:0];
  assign aa = recal_sel_q ? balpha_q[63:48] : balpha_q[47:32];

  // operand select for the shared multiplier
  always_comb begin
    alu_ctrl.start = 1'b0;
    alu_ctrl.op    = igac_pkg::OP_SQ;
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_SCALE: begin
        alu_ctrl.op = igac_pkg::OP_SCALE;
        mul_a = 34'(signed'(raw_q[k_q]));
        mul_b = (k_q < 3'd3) ? 34'(ascale_q) : 34'(gscale_q);
      end
      S_SQ: begin
        mul_a = 34'(rate_q[k_q[1:0]]);
        mul_b = 34'(rate_q[k_q[1:0]]);
      end
      S_THR: begin
        mul_a = 34'(thr_q);
        mul_b = 34'(thr_q);
      end
      S_FILT: begin
        alu_ctrl.op = igac_pkg::OP_EMA;
        mul_a = 34'(rate_q[k_q[1:0]]) - 34'(filt_q[k_q[1:0]]);
        mul_b = 34'(falpha_q);
      end
      S_BIAS: begin
        alu_ctrl.op = igac_pkg::OP_EMA;
        if (k_q < 3'd3) begin
          mul_a = 34'(gsc_q[ax]) - 34'(gbias_q[ax]);
          mul_b = 34'(ga);
        end else begin
          mul_a = 34'(ameas_grav) - 34'(abias_q[ax]);
          mul_b = 34'(aa);
        end
      end
      S_MAG: begin
        mul_a = 34'(filt_q[k_q[1:0]]);
        mul_b = 34'(filt_q[k_q[1:0]]);
      end
      default: ;
    endcase
    // bias products only when tracking an already seeded bias
    if (!wait_q && (state_q == S_SCALE || state_q == S_SQ || state_q == S_THR ||
                    state_q == S_FILT || state_q == S_MAG ||
                    (state_q == S_BIAS && doupd_q && aseed_q)))
      alu_ctrl.start = 1'b1;
  end

  logic signed [31:0] ema_v;
  logic signed [31:0] seed_v;
  logic [31:0]        fmag;
  logic [31:0]        dt;
  assign ema_v = igac_pkg::sat32(66'(filt_q[k_q[1:0]]) + mul_res);
  assign seed_v = fseed_q ? ema_v : rate_q[k_q[1:0]];
  assign fmag = seed_v[31] ? 32'(-33'(seed_v)) : 32'(seed_v);
  assign dt = now_q - last_q;
  assign sq_start = (state_q == S_MAG) && mul_done && k_q == 3'd2;

  assign in_if.ready  = (state_q == S_IDLE);

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= '0;
      wait_q  <= 1'b0;
      fseed_q <= 1'b0;
      aseed_q <= 1'b0;
      upd1_q  <= 1'b0;
      last_q  <= '0;
      run_q   <= '0;
      out_if.valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        gbias_q[i] <= '0;
        abias_q[i] <= '0;
        filt_q[i]  <= '0;
      end
    end else begin
      if (alu_ctrl.start) wait_q <= 1'b1;
      if (mul_done) wait_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_if.valid) begin
            raw_q[0] <= in_if.data.raw_accel_x;
            raw_q[1] <= in_if.data.raw_accel_y;
            raw_q[2] <= in_if.data.raw_accel_z;
            raw_q[3] <= in_if.data.raw_gyro_x;
            raw_q[4] <= in_if.data.raw_gyro_y;
            raw_q[5] <= in_if.data.raw_gyro_z;
            grav_q[0] <= in_if.data.gravity_x;
            grav_q[1] <= in_if.data.gravity_y;
            grav_q[2] <= in_if.data.gravity_z;
            cnt_q <= in_if.data.fusion_still_count;
            now_q <= in_if.data.time_ms;
            k_q <= '0;
            state_q <= S_SCALE;
          end
        end
        S_SCALE: if (mul_done) begin
          if (k_q < 3'd3) begin
            asc_q[ax] <= igac_pkg::sat32(mul_res);
            acc_q[ax] <= igac_pkg::sat32(66'(igac_pkg::sat32(mul_res)) - 66'(abias_q[ax]));
          end else begin
            gsc_q[ax]  <= igac_pkg::sat32(mul_res);
            rate_q[ax] <= igac_pkg::sat32(66'(igac_pkg::sat32(mul_res)) - 66'(gbias_q[ax]));
          end
          if (k_q == 3'd5) begin
            k_q <= '0;
            sum_q <= '0;
            state_q <= S_SQ;
          end else k_q <= k_q + 3'd1;
        end
        S_SQ: if (mul_done) begin
          sum_q <= sum_q + mul_res;
          if (k_q == 3'd2) begin
            k_q <= '0;
            state_q <= S_THR;
          end else k_q <= k_q + 3'd1;
        end
        S_THR: if (mul_done) begin
          if (sum_q < mul_res) begin
            if (run_q != igac_pkg::StillRunMax) run_q <= run_q + 8'd1;
          end else run_q <= '0;
          state_q <= S_FILT;
        end
        S_FILT: if (mul_done) begin
          filt_q[k_q[1:0]] <= (fmag < 32'(db_q)) ? '0 : seed_v;
          if (k_q == 3'd2) begin
            fseed_q <= 1'b1;
            k_q <= '0;
            doupd_q <= (cnt_q >= nstat_q) && (!upd1_q || dt >= recal_q);
            recal_sel_q <= 17'(cnt_q) >= {nstat_q, 1'b0};
            state_q <= S_BIAS;
          end else k_q <= k_q + 3'd1;
        end
        S_BIAS: begin
          if (!doupd_q) begin
            k_q <= '0;
            sum_q <= '0;
            state_q <= S_MAG;
          end else if (!aseed_q) begin
            for (int i = 0; i < 3; i++)
              abias_q[i] <= igac_pkg::sat32(66'(asc_q[i]) - 66'(grav_q[i]));
            aseed_q <= 1'b1;
            upd1_q  <= 1'b1;
            last_q  <= now_q;
            k_q <= '0;
            sum_q <= '0;
            state_q <= S_MAG;
          end else if (mul_done) begin
            if (k_q < 3'd3)
              gbias_q[ax] <= igac_pkg::sat32(66'(gbias_q[ax]) + mul_res);
            else
              abias_q[ax] <= igac_pkg::sat32(66'(abias_q[ax]) + mul_res);
            if (k_q == 3'd5) begin
              upd1_q <= 1'b1;
              last_q <= now_q;
              k_q <= '0;
              sum_q <= '0;
              state_q <= S_MAG;
            end else k_q <= k_q + 3'd1;
          end
        end
        S_MAG: if (mul_done) begin
          sum_q <= sum_q + mul_res;
          if (k_q == 3'd2) state_q <= S_ROOT;
          else k_q <= k_q + 3'd1;
        end
        S_ROOT: if (sq_done) begin
          out_if.data.rate_x <= rate_q[0];
          out_if.data.rate_y <= rate_q[1];
          out_if.data.rate_z <= rate_q[2];
          out_if.data.smooth_x <= filt_q[0];
          out_if.data.smooth_y <= filt_q[1];
          out_if.data.smooth_z <= filt_q[2];
          out_if.data.corrected_accel_x <= acc_q[0];
          out_if.data.corrected_accel_y <= acc_q[1];
          out_if.data.corrected_accel_z <= acc_q[2];
          out_if.data.gyro_still_run <= run_q;
          out_if.data.smooth_magnitude <= root[31:0];
          out_if.valid <= 1'b1;
          state_q <= S_OUT;
        end
        S_OUT: if (out_if.ready) begin
          out_if.valid <= 1'b0;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
